/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define NAT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define NAT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define NAT_ASSERT(lbl, clk, rst_n, prop, msg)

`define NAT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* hdl/nat_pkg.sv */
// ----------------------------------------------------------------------------
// Tokenizer package
// Shared constants, register indexes and structures of the tokenizer.
// ----------------------------------------------------------------------------
package nat_pkg;

    localparam int OFFSET_BITS_DEF    = 16;
    localparam int MAX_DELIMITERS_DEF = 8;
    localparam int MAX_ENCLOSURES_DEF = 2;
    localparam int MAX_PREFIX_DEF     = 4;
    localparam int NEST_BITS_DEF      = 8;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;
    localparam int FIELD_BITS     = 16;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DELIM_BYTES = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DELIM_COUNT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ENCL_PAIRS  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ENCL_COUNT  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PREFIX      = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PREFIX_LEN  = 3'd5;

    localparam logic [63:0] DELIM_BYTES_RST = 64'd32;
    localparam logic [3:0]  DELIM_COUNT_RST = 4'd1;

    typedef struct packed {
        logic [63:0] delimiter_bytes;
        logic [3:0]  delimiter_count;
        logic [31:0] enclosure_pairs;
        logic [1:0]  enclosure_count;
        logic [31:0] comment_prefix;
        logic [2:0]  comment_length;
    } t_cfg;

    typedef struct packed {
        logic       is_delim;
        logic       open_hit;
        logic       open_index;
        logic       close_eq;
        logic       reopen_eq;
        logic       prefix_eq;
        logic [2:0] prefix_len;
    } t_match;

    typedef struct packed {
        logic                  text_done;
        logic                  comment_hit;
        logic                  unterminated;
        logic [FIELD_BITS-1:0] token_ordinal;
        logic [FIELD_BITS-1:0] token_length;
        logic [FIELD_BITS-1:0] token_offset;
        logic                  token_valid;
    } t_result;

endpackage

/* hdl/nat_match.sv */
// ----------------------------------------------------------------------------
// Byte classifier
// Compares one text byte against the delimiter set, the enclosure pairs
// and the comment prefix in parallel.
// ----------------------------------------------------------------------------
module nat_match #(
    parameter int MAX_DELIMITERS = 8,
    parameter int MAX_ENCLOSURES = 2,
    parameter int MAX_PREFIX     = 4
) (
    input  logic [7:0]      i_byte,
    input  nat_pkg::t_cfg   i_cfg,
    input  logic            i_enc_index,
    input  logic [1:0]      i_prefix_index,
    output nat_pkg::t_match o_match
);
    import nat_pkg::*;

    logic [15:0] pair_sel;

    always_comb begin
        o_match.is_delim = 1'b0;
        for (int i = 0; i < MAX_DELIMITERS; i++) begin
            if ((4'(i) < i_cfg.delimiter_count) &&
                (i_cfg.delimiter_bytes[8*i +: 8] == i_byte)) begin
                o_match.is_delim = 1'b1;
            end
        end

        o_match.open_hit   = 1'b0;
        o_match.open_index = 1'b0;
        for (int i = MAX_ENCLOSURES - 1; i >= 0; i--) begin
            if ((2'(i) < i_cfg.enclosure_count) &&
                (i_cfg.enclosure_pairs[16*i +: 8] == i_byte)) begin
                o_match.open_hit   = 1'b1;
                o_match.open_index = 1'(i);
            end
        end

        pair_sel = i_enc_index ? i_cfg.enclosure_pairs[31:16] : i_cfg.enclosure_pairs[15:0];
        o_match.close_eq  = (pair_sel[15:8] == i_byte);
        o_match.reopen_eq = (pair_sel[7:0] == i_byte);

        o_match.prefix_eq  = (i_cfg.comment_prefix[{i_prefix_index, 3'b000} +: 8] == i_byte);
        o_match.prefix_len = (i_cfg.comment_length > 3'(MAX_PREFIX)) ?
                             3'(MAX_PREFIX) : i_cfg.comment_length;
    end

endmodule

/* hdl/nat_scan.sv */
// ----------------------------------------------------------------------------
// Token scanner
// Input register and the per-byte token state update. Produces at most one
// result per byte.
// ----------------------------------------------------------------------------
module nat_scan #(
    parameter int OFFSET_BITS    = 16,
    parameter int MAX_DELIMITERS = 8,
    parameter int MAX_ENCLOSURES = 2,
    parameter int MAX_PREFIX     = 4,
    parameter int NEST_BITS      = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  nat_pkg::t_cfg    i_cfg,
    input  logic             i_tvalid,
    output logic             o_tready,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  logic             i_space,
    output logic             o_push,
    output nat_pkg::t_result o_result
);
    import nat_pkg::*;

    typedef enum logic [1:0] {
        PH_BETWEEN,
        PH_PLAIN,
        PH_ENCLOSED,
        PH_FINISHED
    } t_phase;

    logic                   r_valid;
    logic [7:0]             r_byte;
    logic                   r_last;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_begin, n_begin;
    t_phase                 r_phase, n_phase;
    logic                   r_idx, n_idx;
    logic [NEST_BITS-1:0]   r_nest, n_nest;
    logic [2:0]             r_matched, n_matched;
    logic                   r_alive, n_alive;
    logic [FIELD_BITS-1:0]  r_tokens, n_tokens;

    t_match                 w_match;
    logic                   adv;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [NEST_BITS-1:0]   nest_dec;
    logic                   pa_in;
    logic [2:0]             pm_in;
    logic                   p_live;
    logic                   p_hit;
    logic                   p_alive_nx;
    logic [2:0]             p_matched_nx;
    logic                   tok;
    logic                   tok_unterm;
    logic [OFFSET_BITS-1:0] tok_end;
    logic [OFFSET_BITS-1:0] tok_len;
    logic                   emit;

    assign adv      = r_valid && i_space;
    assign o_tready = !r_valid || i_space;
    assign pos_inc  = (r_pos != '1) ? r_pos + 1'b1 : r_pos;
    assign nest_dec = (r_nest != '0) ? r_nest - 1'b1 : r_nest;

    assign pa_in = (r_phase == PH_BETWEEN) ? (w_match.prefix_len != 3'd0) : r_alive;
    assign pm_in = (r_phase == PH_BETWEEN) ? 3'd0 : r_matched;

    nat_match #(
        .MAX_DELIMITERS (MAX_DELIMITERS),
        .MAX_ENCLOSURES (MAX_ENCLOSURES),
        .MAX_PREFIX     (MAX_PREFIX)
    ) u_match (
        .i_byte         (r_byte),
        .i_cfg          (i_cfg),
        .i_enc_index    (r_idx),
        .i_prefix_index (pm_in[1:0]),
        .o_match        (w_match)
    );

    assign p_live       = pa_in && (pm_in < w_match.prefix_len);
    assign p_hit        = p_live && w_match.prefix_eq && ((pm_in + 3'd1) == w_match.prefix_len);
    assign p_alive_nx   = pa_in && (!p_live || w_match.prefix_eq);
    assign p_matched_nx = (p_live && w_match.prefix_eq) ? pm_in + 3'd1 : pm_in;

    always_comb begin
        n_pos      = r_pos;
        n_begin    = r_begin;
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_nest     = r_nest;
        n_matched  = r_matched;
        n_alive    = r_alive;
        n_tokens   = r_tokens;
        tok        = 1'b0;
        tok_unterm = 1'b0;
        tok_end    = r_pos;
        emit       = 1'b0;

        if (r_phase == PH_FINISHED) begin
            n_phase = PH_FINISHED;
        end else if (r_byte == 8'd0) begin
            tok        = (r_phase == PH_PLAIN) || (r_phase == PH_ENCLOSED);
            tok_unterm = (r_phase == PH_ENCLOSED);
            n_phase    = PH_FINISHED;
            n_alive    = 1'b0;
        end else begin
            n_pos = pos_inc;
            unique case (r_phase)
                PH_BETWEEN: begin
                    if (!w_match.is_delim) begin
                        n_begin   = r_pos;
                        n_phase   = PH_PLAIN;
                        n_alive   = p_alive_nx;
                        n_matched = p_matched_nx;
                        if (w_match.open_hit) begin
                            n_phase = PH_ENCLOSED;
                            n_idx   = w_match.open_index;
                            n_nest  = NEST_BITS'(1);
                        end
                        if (p_hit) begin
                            n_phase = PH_FINISHED;
                        end
                    end
                end
                PH_PLAIN: begin
                    if (w_match.is_delim) begin
                        tok     = 1'b1;
                        tok_end = r_pos;
                    end else begin
                        n_alive   = p_alive_nx;
                        n_matched = p_matched_nx;
                        if (p_hit) begin
                            n_phase = PH_FINISHED;
                        end
                    end
                end
                default: begin
                    n_alive   = p_alive_nx;
                    n_matched = p_matched_nx;
                    if (p_hit) begin
                        n_phase = PH_FINISHED;
                    end else if (w_match.close_eq) begin
                        n_nest = nest_dec;
                        if (nest_dec == '0) begin
                            tok     = 1'b1;
                            tok_end = pos_inc;
                        end
                    end else if (w_match.reopen_eq) begin
                        if (r_nest != '1) begin
                            n_nest = r_nest + 1'b1;
                        end
                    end
                end
            endcase
        end

        if (tok) begin
            n_phase   = (r_byte == 8'd0) ? PH_FINISHED : PH_BETWEEN;
            n_alive   = 1'b0;
            n_matched = 3'd0;
            if (r_tokens != '1) begin
                n_tokens = r_tokens + 1'b1;
            end
            emit = 1'b1;
        end

        o_result.comment_hit = 1'b0;
        if (r_last) begin
            if ((n_phase == PH_PLAIN) || (n_phase == PH_ENCLOSED)) begin
                tok        = 1'b1;
                tok_unterm = (n_phase == PH_ENCLOSED);
                tok_end    = n_pos;
            end
            o_result.comment_hit = (n_phase == PH_FINISHED) && n_alive;
            emit = 1'b1;
        end

        tok_len = tok_end - n_begin;
        o_result.token_valid   = tok;
        o_result.token_offset  = tok ? FIELD_BITS'(n_begin) : '0;
        o_result.token_length  = tok ? FIELD_BITS'(tok_len) : '0;
        o_result.token_ordinal = tok ? r_tokens : '0;
        o_result.unterminated  = tok && tok_unterm;
        o_result.text_done     = r_last;

        if (r_last) begin
            n_pos     = '0;
            n_begin   = '0;
            n_phase   = PH_BETWEEN;
            n_idx     = 1'b0;
            n_nest    = '0;
            n_matched = 3'd0;
            n_alive   = 1'b0;
            n_tokens  = '0;
        end
    end

    assign o_push = adv && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_pos     <= '0;
            r_begin   <= '0;
            r_phase   <= PH_BETWEEN;
            r_idx     <= 1'b0;
            r_nest    <= '0;
            r_matched <= 3'd0;
            r_alive   <= 1'b0;
            r_tokens  <= '0;
        end else begin
            if (o_tready) begin
                r_valid <= i_tvalid;
            end
            if (adv) begin
                r_pos     <= n_pos;
                r_begin   <= n_begin;
                r_phase   <= n_phase;
                r_idx     <= n_idx;
                r_nest    <= n_nest;
                r_matched <= n_matched;
                r_alive   <= n_alive;
                r_tokens  <= n_tokens;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tready && i_tvalid) begin
            r_byte <= i_byte;
            r_last <= i_last;
        end
    end

endmodule

/* hdl/nat_outq.sv */
// ----------------------------------------------------------------------------
// Result queue
// Two-entry result buffer that decouples the scanner from the output side.
// ----------------------------------------------------------------------------
module nat_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  nat_pkg::t_result i_data,
    output logic             o_tvalid,
    input  logic             i_tready,
    output nat_pkg::t_result o_data,
    output logic             o_space,
    output logic             o_pop
);
    import nat_pkg::*;

    t_result    r_q [QUEUE_DEPTH];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    assign o_tvalid = (r_count != 2'd0);
    assign o_data   = r_q[r_rd];
    assign o_pop    = o_tvalid && i_tready;
    assign o_space  = (r_count != 2'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (o_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !o_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && o_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_data;
        end
    end

endmodule

/* hdl/nesting_aware_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// Nesting-aware tokenizer
// Splits a byte stream into tokens, honoring nested enclosures, delimiters
// and a comment prefix, and reports each token's offset, length and ordinal.
//
//   Channel | Direction | Width          | Content
//   --------+-----------+----------------+-----------------------------------
//   s       | in        | 8 + tlast      | one text byte per transfer
//   m       | out       | 48 + 3 + tlast | token report, text end on tlast
//   cfg     | in        | 3 + 64         | register index and write data
//
// One byte is taken per cycle into the input register, and a new transfer
// can be accepted on every clock while the result queue has room. A result
// is offered on the output once the scanner has written it from the input
// register into the result queue. When both queue entries are held, the
// byte in the input register waits and the input stalls. Reset is
// synchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module nesting_aware_tokenizer_unit #(
    parameter int OFFSET_BITS    = nat_pkg::OFFSET_BITS_DEF,
    parameter int MAX_DELIMITERS = nat_pkg::MAX_DELIMITERS_DEF,
    parameter int MAX_ENCLOSURES = nat_pkg::MAX_ENCLOSURES_DEF,
    parameter int MAX_PREFIX     = nat_pkg::MAX_PREFIX_DEF,
    parameter int NEST_BITS      = nat_pkg::NEST_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [7:0]                          i_s_tdata,   // text_byte
    input  logic                                i_s_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [47:0]                         o_m_tdata,   // token_offset, token_length,
                                                             // token_ordinal
    output logic [2:0]                          o_m_tuser,   // token_valid, unterminated,
                                                             // comment_hit
    output logic                                o_m_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [nat_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [nat_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import nat_pkg::*;
    `include "assert_macros.svh"

    t_cfg    r_cfg;
    t_result w_result;
    t_result w_out;
    logic    w_push;
    logic    w_space;
    logic    w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delimiter_bytes <= DELIM_BYTES_RST;
            r_cfg.delimiter_count <= DELIM_COUNT_RST;
            r_cfg.enclosure_pairs <= '0;
            r_cfg.enclosure_count <= '0;
            r_cfg.comment_prefix  <= '0;
            r_cfg.comment_length  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_DELIM_BYTES: r_cfg.delimiter_bytes <= i_cfg_data;
                REG_DELIM_COUNT: r_cfg.delimiter_count <= i_cfg_data[3:0];
                REG_ENCL_PAIRS:  r_cfg.enclosure_pairs <= i_cfg_data[31:0];
                REG_ENCL_COUNT:  r_cfg.enclosure_count <= i_cfg_data[1:0];
                REG_PREFIX:      r_cfg.comment_prefix  <= i_cfg_data[31:0];
                REG_PREFIX_LEN:  r_cfg.comment_length  <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    nat_scan #(
        .OFFSET_BITS    (OFFSET_BITS),
        .MAX_DELIMITERS (MAX_DELIMITERS),
        .MAX_ENCLOSURES (MAX_ENCLOSURES),
        .MAX_PREFIX     (MAX_PREFIX),
        .NEST_BITS      (NEST_BITS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_tvalid (i_s_tvalid),
        .o_tready (o_s_tready),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .i_space  (w_space),
        .o_push   (w_push),
        .o_result (w_result)
    );

    nat_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_result),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_data   (w_out),
        .o_space  (w_space),
        .o_pop    (w_pop)
    );

    assign o_m_tdata = {w_out.token_ordinal, w_out.token_length, w_out.token_offset};
    assign o_m_tuser = {w_out.comment_hit, w_out.unterminated, w_out.token_valid};
    assign o_m_tlast = w_out.text_done;

    `NAT_ASSERT(a_queue_no_overflow, i_clk, i_rst_n, w_push |-> w_space || w_pop, "result queue overflow")
    `NAT_ASSERT(a_comment_at_end, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[2] |-> o_m_tlast && !o_m_tuser[0], "comment flag without text end or with a token")
    `NAT_ASSERT(a_unterm_has_token, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[1] |-> o_m_tuser[0], "unterminated flag without a token")
    `NAT_ASSERT(a_empty_data_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata == 48'd0, "token fields not cleared")

endmodule

/* bench/nesting_aware_tokenizer_unit_test.sv */
// ----------------------------------------------------------------------------
// Nesting-aware tokenizer testbench
// Streams texts into the tokenizer under a series of register settings and
// checks every token report against a cycle-free model of the scanner kept
// in a small scoreboard. The run starts with short hand-written texts, then
// sends random texts built from each setting's delimiters, enclosure
// characters and comment prefix, and ends with one long text that drives
// the nesting depth into saturation.
// ----------------------------------------------------------------------------
module nesting_aware_tokenizer_unit_test;
    import nat_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 6;
    localparam int SLOT_BYTES    = 110;

    localparam int SETUP_RANDOM        = 0;
    localparam int SETUP_MINIMUM       = 1;
    localparam int SETUP_MAXIMUM       = 2;
    localparam int SETUP_COMMENT_CLOSE = 3;

    localparam string DELIM_POOL  = " ,;:|.-\t";
    localparam string PAIR_POOL   = "()[]{}\"\"''<>";
    localparam string PREFIX_POOL = "#/;(\"-a";

    typedef logic [7:0] t_byte_q[$];
    typedef enum logic [1:0] {BETWEEN, IN_PLAIN, IN_ENCLOSED, FINISHED} t_scan_phase;

    class token_tracker;
        logic [63:0] delim_bytes;
        logic [3:0]  delim_count;
        logic [31:0] pairs;
        logic [1:0]  pair_count;
        logic [31:0] prefix;
        logic [2:0]  prefix_count;

        logic [15:0] position;
        logic [15:0] begin_pos;
        logic [15:0] tokens;
        logic [7:0]  depth;
        t_scan_phase phase;
        bit          encl_sel;
        int unsigned matched;
        bit          alive;

        t_result     report;
        t_result     pending_reports[$];
        int          failures;
        int          reports_checked;

        function new();
            delim_bytes  = DELIM_BYTES_RST;
            delim_count  = DELIM_COUNT_RST;
            pairs        = '0;
            pair_count   = '0;
            prefix       = '0;
            prefix_count = '0;
            failures     = 0;
            reports_checked = 0;
            restart();
        endfunction

        function void restart();
            position  = '0;
            begin_pos = '0;
            tokens    = '0;
            depth     = '0;
            phase     = BETWEEN;
            encl_sel  = 1'b0;
            matched   = 0;
            alive     = 1'b0;
        endfunction

        function void set_register(logic [CFG_INDEX_BITS-1:0] index, logic [63:0] value);
            case (index)
                REG_DELIM_BYTES: delim_bytes  = value;
                REG_DELIM_COUNT: delim_count  = value[3:0];
                REG_ENCL_PAIRS:  pairs        = value[31:0];
                REG_ENCL_COUNT:  pair_count   = value[1:0];
                REG_PREFIX:      prefix       = value[31:0];
                REG_PREFIX_LEN:  prefix_count = value[2:0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return pending_reports.size();
        endfunction

        function int prefix_len();
            return (prefix_count > MAX_PREFIX_DEF) ? MAX_PREFIX_DEF : prefix_count;
        endfunction

        function bit is_delimiter(logic [7:0] b);
            int n;
            n = (delim_count > MAX_DELIMITERS_DEF) ? MAX_DELIMITERS_DEF : delim_count;
            for (int i = 0; i < n; i++)
                if (delim_bytes[8*i +: 8] == b) return 1'b1;
            return 1'b0;
        endfunction

        function logic [7:0] pair_byte(int pair, int closing);
            return pairs[16*pair + 8*closing +: 8];
        endfunction

        function bit prefix_step(logic [7:0] b);
            if (!alive || matched >= prefix_len()) return 1'b0;
            if (prefix[8*matched +: 8] == b) begin
                matched++;
                return matched == prefix_len();
            end
            alive = 1'b0;
            return 1'b0;
        endfunction

        function void finish_token(logic [15:0] end_pos, bit unterm);
            report.token_valid   = 1'b1;
            report.token_offset  = begin_pos;
            report.token_length  = end_pos - begin_pos;
            report.token_ordinal = tokens;
            report.unterminated  = unterm;
            if (tokens != 16'hFFFF) tokens++;
            phase   = BETWEEN;
            alive   = 1'b0;
            matched = 0;
        endfunction

        function void note_byte(logic [7:0] b, bit is_last);
            logic [15:0] cur;
            bit          emit;
            int          n;
            report = '0;
            emit   = 1'b0;
            if (phase == FINISHED) begin
            end else if (b == 8'h00) begin
                if (phase == IN_PLAIN) begin
                    finish_token(position, 1'b0);
                    emit = 1'b1;
                end else if (phase == IN_ENCLOSED) begin
                    finish_token(position, 1'b1);
                    emit = 1'b1;
                end
                phase = FINISHED;
                alive = 1'b0;
            end else begin
                cur = position;
                if (position != 16'hFFFF) position++;
                case (phase)
                    BETWEEN: begin
                        if (!is_delimiter(b)) begin
                            n = (pair_count > MAX_ENCLOSURES_DEF) ? MAX_ENCLOSURES_DEF : pair_count;
                            begin_pos = cur;
                            matched   = 0;
                            alive     = prefix_len() > 0;
                            phase     = IN_PLAIN;
                            for (int i = 0; i < n; i++) begin
                                if (pair_byte(i, 0) == b) begin
                                    phase    = IN_ENCLOSED;
                                    encl_sel = i[0];
                                    depth    = 8'd1;
                                    break;
                                end
                            end
                            if (prefix_step(b)) phase = FINISHED;
                        end
                    end
                    IN_PLAIN: begin
                        if (is_delimiter(b)) begin
                            finish_token(cur, 1'b0);
                            emit = 1'b1;
                        end else if (prefix_step(b)) begin
                            phase = FINISHED;
                        end
                    end
                    IN_ENCLOSED: begin
                        if (prefix_step(b)) begin
                            phase = FINISHED;
                        end else if (b == pair_byte(encl_sel, 1)) begin
                            if (depth != 8'd0) depth--;
                            if (depth == 8'd0) begin
                                finish_token(position, 1'b0);
                                emit = 1'b1;
                            end
                        end else if (b == pair_byte(encl_sel, 0)) begin
                            if (depth != 8'hFF) depth++;
                        end
                    end
                    default: ;
                endcase
            end
            if (is_last) begin
                if (phase == IN_PLAIN) finish_token(position, 1'b0);
                else if (phase == IN_ENCLOSED) finish_token(position, 1'b1);
                report.comment_hit = (phase == FINISHED) && alive;
                report.text_done   = 1'b1;
                emit = 1'b1;
                restart();
            end
            if (emit) pending_reports.push_back(report);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_report(logic [47:0] data, logic [2:0] user, logic done);
            t_result want;
            if (pending_reports.size() == 0) begin
                $error("token report with none pending: tdata %h tuser %b tlast %b",
                       data, user, done);
                failures++;
                return;
            end
            want = pending_reports.pop_front();
            reports_checked++;
            compare_field("token_valid", 32'(want.token_valid), 32'(user[0]));
            compare_field("token_offset", 32'(want.token_offset), 32'(data[15:0]));
            compare_field("token_length", 32'(want.token_length), 32'(data[31:16]));
            compare_field("token_ordinal", 32'(want.token_ordinal), 32'(data[47:32]));
            compare_field("unterminated", 32'(want.unterminated), 32'(user[1]));
            compare_field("comment_hit", 32'(want.comment_hit), 32'(user[2]));
            compare_field("text_done", 32'(want.text_done), 32'(done));
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_s_tvalid;
    logic                      o_s_tready;
    logic [7:0]                i_s_tdata;   // text_byte
    logic                      i_s_tlast;
    logic                      o_m_tvalid;
    logic                      i_m_tready;
    logic [47:0]               o_m_tdata;   // token_offset, token_length, token_ordinal
    logic [2:0]                o_m_tuser;   // token_valid, unterminated, comment_hit
    logic                      o_m_tlast;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;

    token_tracker book;
    logic [63:0]  setting [0:5];
    int           send_idle_pct;
    int           recv_idle_pct;
    int           texts_sent;
    int           bytes_sent;
    int           settings_loaded;

    nesting_aware_tokenizer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            book.check_report(o_m_tdata, o_m_tuser, o_m_tlast);
        i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("nesting_aware_tokenizer_unit test failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input bit is_last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= is_last;
        do @(posedge i_clk); while (!o_s_tready);
        book.note_byte(b, is_last);
        bytes_sent++;
    endtask

    task automatic send_text(input t_byte_q txt);
        foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
        texts_sent++;
    endtask

    task automatic wait_for_reports();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (book.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic program_block();
        wait_for_reports();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        for (int r = REG_DELIM_BYTES; r <= REG_PREFIX_LEN; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= r[CFG_INDEX_BITS-1:0];
            i_cfg_data  <= setting[r];
            do @(posedge i_clk); while (!o_cfg_ready);
            book.set_register(r[CFG_INDEX_BITS-1:0], setting[r]);
        end
        i_cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    function automatic t_byte_q text_of(string s);
        t_byte_q q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    function automatic void choose_settings(int kind);
        int p;
        case (kind)
            SETUP_MINIMUM: begin
                foreach (setting[r]) setting[r] = '0;
            end
            SETUP_MAXIMUM: begin
                foreach (setting[r]) setting[r] = '1;
            end
            SETUP_COMMENT_CLOSE: begin
                setting[REG_DELIM_BYTES] = 64'h20;
                setting[REG_DELIM_COUNT] = 64'd9;
                setting[REG_ENCL_PAIRS]  = 64'h2928_2222;
                setting[REG_ENCL_COUNT]  = 64'd3;
                setting[REG_PREFIX]      = 64'h2262_6122;
                setting[REG_PREFIX_LEN]  = 64'd7;
            end
            default: begin
                for (int i = 0; i < 8; i++)
                    setting[REG_DELIM_BYTES][8*i +: 8] = ($urandom_range(0, 9) == 0) ?
                        8'($urandom_range(0, 255)) :
                        8'(DELIM_POOL[$urandom_range(0, DELIM_POOL.len() - 1)]);
                setting[REG_DELIM_COUNT] = 64'($urandom_range(0, 10));
                setting[REG_ENCL_PAIRS]  = '0;
                for (int i = 0; i < 2; i++) begin
                    p = 2 * $urandom_range(0, 5);
                    setting[REG_ENCL_PAIRS][16*i +: 16] = ($urandom_range(0, 6) == 0) ?
                        16'($urandom_range(1, 16'hFFFF)) :
                        {8'(PAIR_POOL[p+1]), 8'(PAIR_POOL[p])};
                end
                setting[REG_ENCL_COUNT] = 64'($urandom_range(0, 3));
                setting[REG_PREFIX]     = '0;
                for (int i = 0; i < 4; i++)
                    setting[REG_PREFIX][8*i +: 8] =
                        8'(PREFIX_POOL[$urandom_range(0, PREFIX_POOL.len() - 1)]);
                setting[REG_PREFIX_LEN] = ($urandom_range(0, 9) < 2) ? 64'd0 :
                                          64'($urandom_range(1, 7));
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return 8'("a" + $urandom_range(0, 25));
        if (r < 55) return setting[REG_DELIM_BYTES][8*$urandom_range(0, 7) +: 8];
        if (r < 67) return setting[REG_ENCL_PAIRS][16*$urandom_range(0, 1) +: 8];
        if (r < 79) return setting[REG_ENCL_PAIRS][16*$urandom_range(0, 1) + 8 +: 8];
        if (r < 86) return setting[REG_PREFIX][8*$urandom_range(0, 3) +: 8];
        if (r < 88) return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_byte_q random_text();
        t_byte_q q;
        int      len;
        int      plen;
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 24);
        plen = (setting[REG_PREFIX_LEN] > 4) ? 4 : int'(setting[REG_PREFIX_LEN]);
        if ($urandom_range(0, 9) == 0) begin
            repeat (len) q.push_back(8'($urandom_range(0, 255)));
            return q;
        end
        while (q.size() < len) begin
            if ($urandom_range(0, 11) == 0) begin
                q.push_back(setting[REG_DELIM_BYTES][7:0]);
                for (int k = 0; k < plen; k++) q.push_back(setting[REG_PREFIX][8*k +: 8]);
            end else begin
                q.push_back(pick_text_byte());
            end
        end
        return q;
    endfunction

    initial begin
        t_byte_q txt;
        int      slot;
        int      slot_bytes;
        book = new();
        texts_sent = 0;
        bytes_sent = 0;
        settings_loaded = 0;
        send_idle_pct = 26;
        recv_idle_pct = 88;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tlast   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        setting[REG_DELIM_BYTES] = 64'h2C20;
        setting[REG_DELIM_COUNT] = 64'd2;
        setting[REG_ENCL_PAIRS]  = 64'h2222_2928;
        setting[REG_ENCL_COUNT]  = 64'd2;
        setting[REG_PREFIX]      = 64'h2F2F;
        setting[REG_PREFIX_LEN]  = 64'd2;
        program_block();
        send_text(text_of("a (b(c))\"q\" //z"));
        txt = {8'hFF, 8'h20, 8'h2F, 8'h78, 8'h00, 8'h71};
        send_text(txt);
        send_text(text_of("(a"));
        send_text(text_of("z"));

        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 26 : (p == 1) ? 88 : 0;
            recv_idle_pct = (p == 0) ? 88 : (p == 1) ? 26 : 0;
            for (int j = 0; j < 3; j++) begin
                slot = 3 * p + j;
                choose_settings(slot == 0 ? SETUP_MINIMUM :
                                slot == 4 ? SETUP_MAXIMUM :
                                slot == 7 ? SETUP_COMMENT_CLOSE : SETUP_RANDOM);
                program_block();
                slot_bytes = 0;
                while (slot_bytes < SLOT_BYTES) begin
                    txt = random_text();
                    slot_bytes += txt.size();
                    send_text(txt);
                    if ($urandom_range(0, 19) == 0) wait_for_reports();
                end
            end
        end

        // One long text: nesting deep enough to saturate the depth counter,
        // followed by twenty-one single-byte tokens.
        setting[REG_DELIM_BYTES] = 64'h20;
        setting[REG_DELIM_COUNT] = 64'd1;
        setting[REG_ENCL_PAIRS]  = 64'h5D5B;
        setting[REG_ENCL_COUNT]  = 64'd1;
        setting[REG_PREFIX]      = 64'h0;
        setting[REG_PREFIX_LEN]  = 64'd0;
        program_block();
        txt = {};
        repeat (260) txt.push_back(8'h5B);
        repeat (255) txt.push_back(8'h5D);
        txt.push_back(8'h20);
        repeat (20) begin
            txt.push_back(8'h61);
            txt.push_back(8'h20);
        end
        txt.push_back(8'h62);
        send_text(txt);

        wait_for_reports();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d texts (%0d bytes) under %0d register settings; %0d token reports",
                 texts_sent, bytes_sent, settings_loaded, book.reports_checked);
        $display("checked, including nesting depth saturation.");
        if (book.failures == 0)
            $display("nesting_aware_tokenizer_unit test passed");
        else
            $display("nesting_aware_tokenizer_unit test failed");
        $finish;
    end

endmodule
